// File: hdl/sse_pkg.sv
// Shared types and constants for the shell sort engine.
// Holds the microcode control word, datapath status flags and sizing constants.
// Used by sse_datapath and shell_sort_engine_unit; depends on nothing.
package sse_pkg;

    localparam int MAX_COUNT = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_COUNT);
    localparam int CNT_W     = $clog2(MAX_COUNT + 1);
    localparam int H_W       = $clog2(3 * MAX_COUNT);
    localparam int STEP_W    = 5;

    localparam int DIV3_SH = 2 * H_W;
    localparam logic [DIV3_SH-1:0] DIV3_MUL = DIV3_SH'(((1 << DIV3_SH) + 2) / 3);

    typedef enum logic [1:0] {H_KEEP, H_ONE, H_GROW, H_DIV3} t_hop;
    typedef enum logic [1:0] {I_KEEP, I_FROM_H, I_INC} t_iop;
    typedef enum logic [1:0] {J_KEEP, J_FROM_I, J_SUB_H} t_jop;
    typedef enum logic [1:0] {RA_I, RA_JMH, RA_K} t_raddr;
    typedef enum logic [1:0] {W_NONE, W_MOVE, W_X} t_wop;
    typedef enum logic [1:0] {K_KEEP, K_CLR, K_INC} t_kop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_LAST_ACC,
        C_N_LT2,
        C_H_GE_N,
        C_H_LE1,
        C_I_GE_N,
        C_J_LT_H,
        C_NOT_GT,
        C_OUT_PEND,
        C_K_LT_N
    } t_cond;

    typedef struct packed {
        t_hop              hop;
        t_iop              iop;
        t_jop              jop;
        t_raddr            raddr;
        t_wop              wop;
        t_kop              kop;
        logic              x_load;
        logic              n_clr;
        logic              out_load;
        logic              in_rdy;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic n_lt2;
        logic h_ge_n;
        logic h_le1;
        logic i_ge_n;
        logic j_lt_h;
        logic rd_gt_x;
        logic k_lt_n;
        logic k_last;
    } t_flags;

endpackage

// File: hdl/sse_datapath.sv
// Datapath of the shell sort engine: element memory, gap and index registers.
// Executes one control word per cycle and reports status flags to the sequencer.
// Depends on sse_pkg.
module sse_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sse_pkg::t_ctrl               i_cw,
    input  logic                         i_load_en,
    input  logic [sse_pkg::DATA_W-1:0]   i_load_value,
    output logic [sse_pkg::DATA_W-1:0]   o_rd_data,
    output sse_pkg::t_flags              o_flags
);

    logic [sse_pkg::DATA_W-1:0] r_mem [sse_pkg::MAX_COUNT];
    logic [sse_pkg::DATA_W-1:0] r_rd_data;
    logic [sse_pkg::DATA_W-1:0] r_x;
    logic [sse_pkg::CNT_W-1:0]  r_n, n_n;
    logic [sse_pkg::H_W-1:0]    r_h, n_h;
    logic [sse_pkg::CNT_W-1:0]  r_i, n_i;
    logic [sse_pkg::CNT_W-1:0]  r_j, n_j;
    logic [sse_pkg::CNT_W-1:0]  r_k, n_k;

    logic [sse_pkg::H_W-1:0]             n_ext;
    logic [sse_pkg::H_W-1:0]             j_ext;
    logic [sse_pkg::CNT_W-1:0]           h_c;
    logic [sse_pkg::CNT_W-1:0]           jmh;
    logic [3*sse_pkg::H_W-1:0]           div_prod;
    logic [sse_pkg::IDX_W-1:0]           rd_addr;
    logic                                room;
    logic                                we;
    logic [sse_pkg::IDX_W-1:0]           wr_addr;
    logic [sse_pkg::DATA_W-1:0]          wr_data;

    assign n_ext    = sse_pkg::H_W'(r_n);
    assign j_ext    = sse_pkg::H_W'(r_j);
    assign h_c      = r_h[sse_pkg::CNT_W-1:0];
    assign jmh      = r_j - h_c;
    assign div_prod = (3*sse_pkg::H_W)'(r_h) * (3*sse_pkg::H_W)'(sse_pkg::DIV3_MUL);
    assign room     = r_n < sse_pkg::CNT_W'(sse_pkg::MAX_COUNT);

    always_comb begin
        unique case (i_cw.hop)
            sse_pkg::H_ONE:  n_h = sse_pkg::H_W'(1);
            sse_pkg::H_GROW: n_h = (r_h << 1) + r_h + sse_pkg::H_W'(1);
            sse_pkg::H_DIV3: n_h = div_prod[sse_pkg::DIV3_SH +: sse_pkg::H_W];
            default:         n_h = r_h;
        endcase
        unique case (i_cw.iop)
            sse_pkg::I_FROM_H: n_i = h_c;
            sse_pkg::I_INC:    n_i = r_i + sse_pkg::CNT_W'(1);
            default:           n_i = r_i;
        endcase
        unique case (i_cw.jop)
            sse_pkg::J_FROM_I: n_j = r_i;
            sse_pkg::J_SUB_H:  n_j = jmh;
            default:           n_j = r_j;
        endcase
        unique case (i_cw.kop)
            sse_pkg::K_CLR: n_k = '0;
            sse_pkg::K_INC: n_k = r_k + sse_pkg::CNT_W'(1);
            default:        n_k = r_k;
        endcase
        unique case (i_cw.raddr)
            sse_pkg::RA_JMH: rd_addr = jmh[sse_pkg::IDX_W-1:0];
            sse_pkg::RA_K:   rd_addr = r_k[sse_pkg::IDX_W-1:0];
            default:         rd_addr = r_i[sse_pkg::IDX_W-1:0];
        endcase
        priority if (i_cw.n_clr) begin
            n_n = '0;
        end else if (i_load_en && room) begin
            n_n = r_n + sse_pkg::CNT_W'(1);
        end else begin
            n_n = r_n;
        end
        priority if (i_load_en) begin
            we      = room;
            wr_addr = r_n[sse_pkg::IDX_W-1:0];
            wr_data = i_load_value;
        end else begin
            we      = (i_cw.wop == sse_pkg::W_MOVE) || (i_cw.wop == sse_pkg::W_X);
            wr_addr = r_j[sse_pkg::IDX_W-1:0];
            wr_data = (i_cw.wop == sse_pkg::W_X) ? r_x : r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else begin
            r_n <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        if (i_cw.x_load) begin
            r_x <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_rd_data       = r_rd_data;
    assign o_flags.n_lt2   = r_n < sse_pkg::CNT_W'(2);
    assign o_flags.h_ge_n  = r_h >= n_ext;
    assign o_flags.h_le1   = r_h <= sse_pkg::H_W'(1);
    assign o_flags.i_ge_n  = r_i >= r_n;
    assign o_flags.j_lt_h  = j_ext < r_h;
    assign o_flags.rd_gt_x = $signed(r_rd_data) > $signed(r_x);
    assign o_flags.k_lt_n  = r_k < r_n;
    assign o_flags.k_last  = (r_k + sse_pkg::CNT_W'(1)) == r_n;

endmodule

// File: hdl/shell_sort_engine_unit.sv
// Shell sort engine top level: microcode sequencer, stream ports, output register.
// After the word marked last, the first sorted word appears once the gapped
// insertion passes finish; each element move runs S_WHILE, S_CMP and S_MOVE.
// Throughput: 1 input word per cycle while loading; each output word steps
// through S_EREAD, S_EWAIT, S_EMIT and S_ENEXT, waiting in S_EWAIT while output is held.
// Reset: synchronous active low; clears the element count, the step counter and output valid.
module shell_sort_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // value[31:0]
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // sorted_value[31:0]
    output logic        o_m_axis_tlast    // end_of_set
);

    localparam logic [sse_pkg::STEP_W-1:0] S_IDLE   = 5'd0;
    localparam logic [sse_pkg::STEP_W-1:0] S_INIT   = 5'd1;
    localparam logic [sse_pkg::STEP_W-1:0] S_GTEST  = 5'd2;
    localparam logic [sse_pkg::STEP_W-1:0] S_GROW   = 5'd3;
    localparam logic [sse_pkg::STEP_W-1:0] S_PASS   = 5'd4;
    localparam logic [sse_pkg::STEP_W-1:0] S_DIV    = 5'd5;
    localparam logic [sse_pkg::STEP_W-1:0] S_ISET   = 5'd6;
    localparam logic [sse_pkg::STEP_W-1:0] S_FOR    = 5'd7;
    localparam logic [sse_pkg::STEP_W-1:0] S_TAKEX  = 5'd8;
    localparam logic [sse_pkg::STEP_W-1:0] S_WHILE  = 5'd9;
    localparam logic [sse_pkg::STEP_W-1:0] S_CMP    = 5'd10;
    localparam logic [sse_pkg::STEP_W-1:0] S_MOVE   = 5'd11;
    localparam logic [sse_pkg::STEP_W-1:0] S_PLACE  = 5'd12;
    localparam logic [sse_pkg::STEP_W-1:0] S_EINIT  = 5'd13;
    localparam logic [sse_pkg::STEP_W-1:0] S_EREAD  = 5'd14;
    localparam logic [sse_pkg::STEP_W-1:0] S_EWAIT  = 5'd15;
    localparam logic [sse_pkg::STEP_W-1:0] S_EMIT   = 5'd16;
    localparam logic [sse_pkg::STEP_W-1:0] S_ENEXT  = 5'd17;
    localparam logic [sse_pkg::STEP_W-1:0] S_DONE   = 5'd18;

    function automatic sse_pkg::t_ctrl rom(input logic [sse_pkg::STEP_W-1:0] pc);
        sse_pkg::t_ctrl ctl;
        ctl = '{hop: sse_pkg::H_KEEP, iop: sse_pkg::I_KEEP, jop: sse_pkg::J_KEEP,
                raddr: sse_pkg::RA_I, wop: sse_pkg::W_NONE, kop: sse_pkg::K_KEEP,
                x_load: 1'b0, n_clr: 1'b0, out_load: 1'b0, in_rdy: 1'b0,
                cond: sse_pkg::C_NEVER, target: S_IDLE};
        unique case (pc)
            S_IDLE: begin
                ctl.in_rdy = 1'b1;
                ctl.cond   = sse_pkg::C_NOT_LAST_ACC;
                ctl.target = S_IDLE;
            end
            S_INIT: begin
                ctl.hop    = sse_pkg::H_ONE;
                ctl.cond   = sse_pkg::C_N_LT2;
                ctl.target = S_EINIT;
            end
            S_GTEST: begin
                ctl.cond   = sse_pkg::C_H_GE_N;
                ctl.target = S_PASS;
            end
            S_GROW: begin
                ctl.hop    = sse_pkg::H_GROW;
                ctl.cond   = sse_pkg::C_ALWAYS;
                ctl.target = S_GTEST;
            end
            S_PASS: begin
                ctl.cond   = sse_pkg::C_H_LE1;
                ctl.target = S_EINIT;
            end
            S_DIV: begin
                ctl.hop = sse_pkg::H_DIV3;
            end
            S_ISET: begin
                ctl.iop = sse_pkg::I_FROM_H;
            end
            S_FOR: begin
                ctl.raddr  = sse_pkg::RA_I;
                ctl.cond   = sse_pkg::C_I_GE_N;
                ctl.target = S_PASS;
            end
            S_TAKEX: begin
                ctl.x_load = 1'b1;
                ctl.jop    = sse_pkg::J_FROM_I;
            end
            S_WHILE: begin
                ctl.raddr  = sse_pkg::RA_JMH;
                ctl.cond   = sse_pkg::C_J_LT_H;
                ctl.target = S_PLACE;
            end
            S_CMP: begin
                ctl.raddr  = sse_pkg::RA_JMH;
                ctl.cond   = sse_pkg::C_NOT_GT;
                ctl.target = S_PLACE;
            end
            S_MOVE: begin
                ctl.wop    = sse_pkg::W_MOVE;
                ctl.jop    = sse_pkg::J_SUB_H;
                ctl.cond   = sse_pkg::C_ALWAYS;
                ctl.target = S_WHILE;
            end
            S_PLACE: begin
                ctl.wop    = sse_pkg::W_X;
                ctl.iop    = sse_pkg::I_INC;
                ctl.cond   = sse_pkg::C_ALWAYS;
                ctl.target = S_FOR;
            end
            S_EINIT: begin
                ctl.kop = sse_pkg::K_CLR;
            end
            S_EREAD: begin
                ctl.raddr = sse_pkg::RA_K;
            end
            S_EWAIT: begin
                ctl.raddr  = sse_pkg::RA_K;
                ctl.cond   = sse_pkg::C_OUT_PEND;
                ctl.target = S_EWAIT;
            end
            S_EMIT: begin
                ctl.raddr    = sse_pkg::RA_K;
                ctl.out_load = 1'b1;
                ctl.kop      = sse_pkg::K_INC;
            end
            S_ENEXT: begin
                ctl.cond   = sse_pkg::C_K_LT_N;
                ctl.target = S_EREAD;
            end
            S_DONE: begin
                ctl.n_clr  = 1'b1;
                ctl.cond   = sse_pkg::C_ALWAYS;
                ctl.target = S_IDLE;
            end
            default: begin
                ctl.cond   = sse_pkg::C_ALWAYS;
                ctl.target = S_IDLE;
            end
        endcase
        return ctl;
    endfunction

    logic [sse_pkg::STEP_W-1:0] r_pc, n_pc;
    logic                       r_out_valid;
    logic [31:0]                r_out_data;
    logic                       r_out_last;

    sse_pkg::t_ctrl             cw;
    sse_pkg::t_flags            flags;
    logic [sse_pkg::DATA_W-1:0] rd_data;
    logic                       in_acc;
    logic                       out_pend;
    logic                       take;

    assign cw       = rom(r_pc);
    assign in_acc   = i_s_axis_tvalid && cw.in_rdy;
    assign out_pend = r_out_valid && !i_m_axis_tready;

    sse_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cw         (cw),
        .i_load_en    (in_acc),
        .i_load_value (i_s_axis_tdata),
        .o_rd_data    (rd_data),
        .o_flags      (flags)
    );

    always_comb begin
        unique case (cw.cond)
            sse_pkg::C_ALWAYS:       take = 1'b1;
            sse_pkg::C_NOT_LAST_ACC: take = !(in_acc && i_s_axis_tlast);
            sse_pkg::C_N_LT2:        take = flags.n_lt2;
            sse_pkg::C_H_GE_N:       take = flags.h_ge_n;
            sse_pkg::C_H_LE1:        take = flags.h_le1;
            sse_pkg::C_I_GE_N:       take = flags.i_ge_n;
            sse_pkg::C_J_LT_H:       take = flags.j_lt_h;
            sse_pkg::C_NOT_GT:       take = !flags.rd_gt_x;
            sse_pkg::C_OUT_PEND:     take = out_pend;
            sse_pkg::C_K_LT_N:       take = flags.k_lt_n;
            default:                 take = 1'b0;
        endcase
        n_pc = take ? cw.target : r_pc + sse_pkg::STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (cw.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cw.out_load) begin
            r_out_data <= rd_data;
            r_out_last <= flags.k_last;
        end
    end

    assign o_s_axis_tready = cw.in_rdy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_EMIT) |-> !r_out_valid)
        else $error("output register still busy when a sorted word is loaded");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pc == S_EMIT))
        else $error("output word raised outside the emit step");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= S_DONE)
        else $error("step counter left the program");

endmodule
